### rtl/sdspi_pkg.sv
// Package for the SD card SPI-mode init and read sequencer.
// Holds the sequencer phase and code types, word structs and the command frame table.
// No dependencies.
package sdspi_pkg;

  // Config register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgRetryLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWakeBytes  = 1'b1;

  // Reset values of the config registers
  localparam logic [7:0] RetryLimitRst = 8'd255;
  localparam logic [7:0] WakeBytesRst  = 8'd10;

  // Bytes on the SPI bus
  localparam logic [7:0] ByteIdle  = 8'hFF;
  localparam logic [7:0] R1Idle    = 8'h01;
  localparam logic [7:0] R1Ready   = 8'h00;
  localparam logic [7:0] DataToken = 8'hFE;
  localparam logic [15:0] EchoGood = 16'h01AA;

  // Command frames: command byte, argument, CRC byte
  localparam logic [7:0]  Cmd0Byte   = 8'h40;
  localparam logic [7:0]  Cmd0Crc    = 8'h95;
  localparam logic [7:0]  Cmd8Byte   = 8'h48;
  localparam logic [31:0] Cmd8Arg    = 32'h0000_01AA;
  localparam logic [7:0]  Cmd8Crc    = 8'h87;
  localparam logic [7:0]  Cmd55Byte  = 8'h77;
  localparam logic [7:0]  Acmd41Byte = 8'h69;
  localparam logic [31:0] Acmd41Arg  = 32'h4000_0000;
  localparam logic [7:0]  Cmd17Byte  = 8'h51;
  localparam logic [7:0]  DummyCrc   = 8'hFF;

  // Frame byte positions
  localparam logic [2:0] FrameLast = 3'd6;
  localparam logic [2:0] TailLast  = 3'd4;
  localparam logic [2:0] EchoHiPos = 3'd2;
  localparam logic [2:0] EchoLoPos = 3'd3;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_INIT  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_OTHER = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_INIT_OK   = 3'd1,
    ST_NO_CARD   = 3'd2,
    ST_NOT_COMPAT = 3'd3,
    ST_INIT_TMO  = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_READ_REJ  = 3'd6,
    ST_BAD_TOKEN = 3'd7
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE,
    PH_CMD0_TX, PH_CMD0_R1, PH_DRAIN0,
    PH_CMD8_TX, PH_CMD8_R1, PH_CMD8_TAIL, PH_DRAIN8,
    PH_CMD55_TX, PH_CMD55_R1, PH_CMD41_TX, PH_CMD41_R1,
    PH_RD_DRAIN, PH_CMD17_TX, PH_CMD17_R1, PH_RD_TOKEN, PH_RD_DATA
  } phase_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  rx_byte;
    logic [31:0] address;
    logic [15:0] read_size;
  } sdspi_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       select_low;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       done_res;
  } sdspi_res_t;

  typedef struct packed {
    logic [7:0] retry_limit;
    logic [7:0] wake_bytes;
  } sdspi_cfg_t;

  // Byte idx of the command frame sent in a TX phase
  function automatic logic [7:0] frame_byte(phase_e ph, logic [2:0] idx,
                                             logic [31:0] rd_addr);
    logic [7:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    cmd = Cmd0Byte;
    arg = '0;
    crc = Cmd0Crc;
    unique case (ph)
      PH_CMD8_TX: begin
        cmd = Cmd8Byte; arg = Cmd8Arg; crc = Cmd8Crc;
      end
      PH_CMD55_TX: begin
        cmd = Cmd55Byte; arg = '0; crc = DummyCrc;
      end
      PH_CMD41_TX: begin
        cmd = Acmd41Byte; arg = Acmd41Arg; crc = DummyCrc;
      end
      PH_CMD17_TX: begin
        cmd = Cmd17Byte; arg = rd_addr; crc = DummyCrc;
      end
      default: ;
    endcase
    unique case (idx)
      3'd0:    b = ByteIdle;
      3'd1:    b = cmd;
      3'd2:    b = arg[31:24];
      3'd3:    b = arg[23:16];
      3'd4:    b = arg[15:8];
      3'd5:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

### rtl/sdspi_if.sv
// Valid/ready channel interfaces of the SD card SPI sequencer.
// Depends on sdspi_pkg for the register index width.
interface sdspi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  rx_byte;
  logic [31:0] address;
  logic [15:0] read_size;
  modport source (output valid, action, rx_byte, address, read_size, input ready);
  modport sink   (input valid, action, rx_byte, address, read_size, output ready);
endinterface

interface sdspi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       select_low;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [2:0] status;
  logic       done_res;
  modport source (output valid, tx_byte, select_low, data_valid, data_byte, status,
                  done_res, input ready);
  modport sink   (input valid, tx_byte, select_low, data_valid, data_byte, status,
                  done_res, output ready);
endinterface

interface sdspi_cfg_if;
  import sdspi_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [7:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sdspi_cfg.sv
// Config register file of the SD card SPI sequencer: retry limit and wake count.
// Depends on sdspi_pkg and sdspi_if.
module sdspi_cfg
  import sdspi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sdspi_cfg_if.sink   cfg_i,
  output sdspi_cfg_t  cfg_o
);

  logic [7:0] retry_limit_q;
  logic [7:0] wake_bytes_q;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RetryLimitRst;
      wake_bytes_q  <= WakeBytesRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgRetryLimit: retry_limit_q <= cfg_i.data;
        CfgWakeBytes:  wake_bytes_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o.retry_limit = retry_limit_q;
  assign cfg_o.wake_bytes  = wake_bytes_q;

endmodule

### rtl/sdspi_seq.sv
// Protocol sequencer of the SD card SPI host: phase machine, counters and result word.
// Depends on sdspi_pkg.
module sdspi_seq
  import sdspi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  sdspi_item_t item_i,
  input  sdspi_cfg_t  cfg_i,
  output sdspi_res_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  byte_index_q, byte_index_d;
  logic [7:0]  retry_count_q, retry_count_d;
  logic [31:0] read_address_q, read_address_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [15:0] echo_bytes_q, echo_bytes_d;

  action_e     act;
  logic        rx_ff, rx_idle, rx_ready, rx_token;
  logic        wake_more, retry_more, frame_more, tail_more;
  logic        echo_ok, left_zero, last_data;
  logic [15:0] left_m1;
  logic [2:0]  index_p1;

  // Decode of the incoming word
  assign act        = action_e'(item_i.action);
  assign rx_ff      = (item_i.rx_byte == ByteIdle);
  assign rx_idle    = (item_i.rx_byte == R1Idle);
  assign rx_ready   = (item_i.rx_byte == R1Ready);
  assign rx_token   = (item_i.rx_byte == DataToken);
  assign wake_more  = (retry_count_q < cfg_i.wake_bytes);
  assign retry_more = (retry_count_q < cfg_i.retry_limit);
  assign frame_more = (byte_index_q < FrameLast);
  assign tail_more  = (byte_index_q < TailLast);
  assign index_p1   = byte_index_q + 3'd1;
  assign echo_ok    = (echo_bytes_q == EchoGood);
  assign left_zero  = (bytes_left_q == '0);
  assign left_m1    = bytes_left_q - 16'd1;
  assign last_data  = (left_m1 == '0);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (act == ACT_INIT) begin
      phase_d = PH_WAKE;
    end else if (act == ACT_READ) begin
      phase_d = PH_RD_DRAIN;
    end else begin
      unique case (phase_q)
        PH_WAKE:      phase_d = wake_more ? PH_WAKE : PH_CMD0_TX;
        PH_CMD0_TX:   phase_d = frame_more ? PH_CMD0_TX : PH_CMD0_R1;
        PH_CMD8_TX:   phase_d = frame_more ? PH_CMD8_TX : PH_CMD8_R1;
        PH_CMD55_TX:  phase_d = frame_more ? PH_CMD55_TX : PH_CMD55_R1;
        PH_CMD41_TX:  phase_d = frame_more ? PH_CMD41_TX : PH_CMD41_R1;
        PH_CMD17_TX:  phase_d = frame_more ? PH_CMD17_TX : PH_CMD17_R1;
        PH_CMD0_R1: begin
          if (rx_ff)           phase_d = PH_CMD0_R1;
          else if (rx_idle)    phase_d = PH_DRAIN0;
          else if (retry_more) phase_d = PH_CMD0_TX;
          else                 phase_d = PH_IDLE;
        end
        PH_DRAIN0:    phase_d = rx_ff ? PH_CMD8_TX : PH_DRAIN0;
        PH_CMD8_R1:   phase_d = rx_ff ? PH_CMD8_R1 : PH_CMD8_TAIL;
        PH_CMD8_TAIL: begin
          if (tail_more)    phase_d = PH_CMD8_TAIL;
          else if (echo_ok) phase_d = PH_DRAIN8;
          else              phase_d = PH_IDLE;
        end
        PH_DRAIN8:    phase_d = rx_ff ? PH_CMD55_TX : PH_DRAIN8;
        PH_CMD55_R1:  phase_d = rx_ff ? PH_CMD55_R1 : PH_CMD41_TX;
        PH_CMD41_R1: begin
          if (rx_ff)           phase_d = PH_CMD41_R1;
          else if (rx_ready)   phase_d = PH_IDLE;
          else if (retry_more) phase_d = PH_CMD55_TX;
          else                 phase_d = PH_IDLE;
        end
        PH_RD_DRAIN:  phase_d = rx_ff ? PH_CMD17_TX : PH_RD_DRAIN;
        PH_CMD17_R1: begin
          if (rx_ff)         phase_d = PH_CMD17_R1;
          else if (rx_ready) phase_d = PH_RD_TOKEN;
          else               phase_d = PH_IDLE;
        end
        PH_RD_TOKEN: begin
          if (rx_ff)                      phase_d = PH_RD_TOKEN;
          else if (rx_token && !left_zero) phase_d = PH_RD_DATA;
          else                            phase_d = PH_IDLE;
        end
        PH_RD_DATA:   phase_d = last_data ? PH_IDLE : PH_RD_DATA;
        default:      phase_d = PH_IDLE;
      endcase
    end
  end

  // Result word and counter updates
  always_comb begin
    byte_index_d   = byte_index_q;
    retry_count_d  = retry_count_q;
    read_address_d = read_address_q;
    bytes_left_d   = bytes_left_q;
    echo_bytes_d   = echo_bytes_q;
    res_o.tx_byte    = ByteIdle;
    res_o.select_low = 1'b1;
    res_o.data_valid = 1'b0;
    res_o.data_byte  = '0;
    res_o.status     = ST_BUSY;
    res_o.done_res   = 1'b0;
    if (act == ACT_INIT) begin
      res_o.select_low = 1'b0;
      byte_index_d     = '0;
      retry_count_d    = 8'd1;
    end else if (act == ACT_READ) begin
      read_address_d = item_i.address;
      bytes_left_d   = item_i.read_size;
      byte_index_d   = '0;
    end else begin
      unique case (phase_q)
        PH_WAKE: begin
          if (wake_more) begin
            retry_count_d    = retry_count_q + 8'd1;
            res_o.select_low = 1'b0;
          end else begin
            retry_count_d = '0;
            byte_index_d  = '0;
          end
        end
        PH_CMD0_TX, PH_CMD8_TX, PH_CMD55_TX, PH_CMD41_TX, PH_CMD17_TX: begin
          if (frame_more) begin
            byte_index_d  = index_p1;
            res_o.tx_byte = frame_byte(phase_q, index_p1, read_address_q);
          end else begin
            byte_index_d = '0;
          end
        end
        PH_CMD0_R1: begin
          if (!rx_ff && !rx_idle) begin
            byte_index_d = '0;
            if (retry_more) begin
              retry_count_d = retry_count_q + 8'd1;
            end else begin
              res_o.select_low = 1'b0;
              res_o.status     = ST_NO_CARD;
              res_o.done_res   = 1'b1;
            end
          end
        end
        PH_DRAIN0, PH_CMD55_R1, PH_RD_DRAIN: begin
          if (rx_ff == (phase_q != PH_CMD55_R1)) byte_index_d = '0;
        end
        PH_CMD8_R1: begin
          if (!rx_ff) begin
            echo_bytes_d = 16'hFFFF;
            byte_index_d = '0;
          end
        end
        PH_CMD8_TAIL: begin
          if (byte_index_q == EchoHiPos) echo_bytes_d[15:8] = item_i.rx_byte;
          else if (byte_index_q == EchoLoPos) echo_bytes_d[7:0] = item_i.rx_byte;
          if (tail_more) begin
            byte_index_d = index_p1;
          end else begin
            byte_index_d = '0;
            if (!echo_ok) begin
              res_o.select_low = 1'b0;
              res_o.status     = ST_NOT_COMPAT;
              res_o.done_res   = 1'b1;
            end
          end
        end
        PH_DRAIN8: begin
          if (rx_ff) begin
            retry_count_d = '0;
            byte_index_d  = '0;
          end
        end
        PH_CMD41_R1: begin
          if (!rx_ff) begin
            byte_index_d = '0;
            if (rx_ready) begin
              res_o.select_low = 1'b0;
              res_o.status     = ST_INIT_OK;
              res_o.done_res   = 1'b1;
            end else if (retry_more) begin
              retry_count_d = retry_count_q + 8'd1;
            end else begin
              res_o.select_low = 1'b0;
              res_o.status     = ST_INIT_TMO;
              res_o.done_res   = 1'b1;
            end
          end
        end
        PH_CMD17_R1: begin
          if (!rx_ff && !rx_ready) begin
            byte_index_d     = '0;
            res_o.select_low = 1'b0;
            res_o.status     = ST_READ_REJ;
            res_o.done_res   = 1'b1;
          end
        end
        PH_RD_TOKEN: begin
          if (!rx_ff) begin
            if (!rx_token) begin
              byte_index_d     = '0;
              res_o.select_low = 1'b0;
              res_o.status     = ST_BAD_TOKEN;
              res_o.done_res   = 1'b1;
            end else if (left_zero) begin
              byte_index_d     = '0;
              res_o.select_low = 1'b0;
              res_o.status     = ST_READ_OK;
              res_o.done_res   = 1'b1;
            end
          end
        end
        PH_RD_DATA: begin
          bytes_left_d     = left_m1;
          res_o.data_valid = 1'b1;
          res_o.data_byte  = item_i.rx_byte;
          if (last_data) begin
            byte_index_d     = '0;
            res_o.select_low = 1'b0;
            res_o.status     = ST_READ_OK;
            res_o.done_res   = 1'b1;
          end
        end
        default: begin
          // idle: bus released
          res_o.select_low = 1'b0;
        end
      endcase
    end
  end

  // State registers, advanced once per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      byte_index_q   <= '0;
      retry_count_q  <= '0;
      read_address_q <= '0;
      bytes_left_q   <= '0;
      echo_bytes_q   <= 16'hFFFF;
    end else if (step_i) begin
      phase_q        <= phase_d;
      byte_index_q   <= byte_index_d;
      retry_count_q  <= retry_count_d;
      read_address_q <= read_address_d;
      bytes_left_q   <= bytes_left_d;
      echo_bytes_q   <= echo_bytes_d;
    end
  end

endmodule

### rtl/sd_card_spi_init_and_read.sv
// Top level of the SD card SPI-mode init and single block read sequencer.
// Depends on sdspi_pkg, sdspi_if, sdspi_cfg and sdspi_seq.
//
// Usage:
//   in_i  : one word per SPI byte exchange. action 0 reports the byte just
//           received (rx_byte), 1 starts card init, 2 starts a block read at
//           address for read_size bytes. action 3 acts as 0.
//   out_o : one word per input word: next byte to send, chip select level,
//           an optional captured data byte and the final status with done_res.
//   cfg_i : register writes, index 0 retry limit, index 1 wake byte count.
//           Write only while no word is in flight.
// From input accept to result valid a word passes an input register, then the
// sequencer step into the result register. Throughput is one word per cycle
// while out_o is ready; the sequencer phase update loops through its own register.
// Reset puts the sequencer idle with chip select released, and loads the
// registers with retry limit 255 and wake count 10.
// When the receiver stalls, the result register holds and the input register
// still takes one more word, after which in_i.ready drops until out_o drains.
module sd_card_spi_init_and_read
  import sdspi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  sdspi_in_if.sink     in_i,
  sdspi_out_if.source  out_o,
  sdspi_cfg_if.sink    cfg_i
);

  sdspi_cfg_t  cfg;
  sdspi_item_t item_q;
  logic        item_valid_q;
  sdspi_res_t  res;
  sdspi_res_t  res_q;
  logic        res_valid_q;
  logic        advance;
  logic        step;

  sdspi_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Pipeline moves when the result slot is free or being taken
  assign advance    = !res_valid_q || out_o.ready;
  assign step       = item_valid_q && advance;
  assign in_i.ready = !item_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.action    <= in_i.action;
      item_q.rx_byte   <= in_i.rx_byte;
      item_q.address   <= in_i.address;
      item_q.read_size <= in_i.read_size;
    end
  end

  sdspi_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.tx_byte    = res_q.tx_byte;
  assign out_o.select_low = res_q.select_low;
  assign out_o.data_valid = res_q.data_valid;
  assign out_o.data_byte  = res_q.data_byte;
  assign out_o.status     = res_q.status;
  assign out_o.done_res   = res_q.done_res;

endmodule
